// ===== sv/dqdel_pkg.sv =====
// ----------------------------------------------------------------------------
// dqdel_pkg
// shared types for the bounded doubly linked list unit: opcodes and status
// ----------------------------------------------------------------------------
`default_nettype none

package dqdel_pkg;

    typedef enum logic [1:0] {
        OP_INSERT_FRONT = 2'd0,
        OP_DEL_VALUE    = 2'd1,
        OP_DEL_FIRST    = 2'd2,
        OP_DEL_LAST     = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 11;

endpackage : dqdel_pkg

`default_nettype wire

// ===== sv/dqdel_ram.sv =====
// ----------------------------------------------------------------------------
// dqdel_ram
// simple dual port node store: one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module dqdel_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule : dqdel_ram

`default_nettype wire

// ===== sv/deque_with_delete_by_value_unit.sv =====
// ----------------------------------------------------------------------------
// deque_with_delete_by_value_unit
// bounded doubly linked list of signed 32-bit values with delete by value
// ----------------------------------------------------------------------------
// usage
//   a command beat (opcode, item_value) is taken on a rising edge with start
//   high and busy low; busy stays high until the result has been shown
//   opcodes: insert at front, delete first match from head, delete first,
//   delete last
//   one result beat per command: done is high for exactly one cycle with
//   status, removed_value and entry_count; the receiver cannot stall it
// state path, from the accepting edge to the done cycle
//   empty list or full list: straight to done
//   insert: write the new node, then fix the old head's back link; a reused
//   slot first has its free chain link loaded and checked
//   delete first or last: load and check the node, bridge its neighbours,
//   then push the slot on the free chain
//   delete by value: each node from the head gets one registered read of the node
//   store, then one pass through the shared value comparator; a match is unlinked as above
//   busy drops in the cycle after done, so one command runs at a time
// reset
//   list empty, free chain empty, no slot used; the node stores need no
//   clearing since a link only ever points at a written slot
// ----------------------------------------------------------------------------
`default_nettype none

module deque_with_delete_by_value_unit
    import dqdel_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [1:0]                opcode,
    input  wire logic signed [VALUE_W-1:0] item_value,
    output logic                           done,
    output logic      [1:0]                status,
    output logic signed [VALUE_W-1:0]      removed_value,
    output logic      [COUNT_W-1:0]        entry_count
);

    // index width holds the null code, address width only real slots
    localparam int IW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam logic [IW-1:0] NIL       = IW'(CAPACITY);
    localparam logic [AW-1:0] LAST_STEP = AW'(CAPACITY - 1);

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_LOAD      = 8'b0000_0010,  // node read in flight
        S_CHECK     = 8'b0000_0100,  // node data valid, compare
        S_INS_LINK  = 8'b0000_1000,  // write new node
        S_INS_FIX   = 8'b0001_0000,  // back link of old head
        S_UNL_LINK  = 8'b0010_0000,  // bridge neighbours
        S_UNL_FREE  = 8'b0100_0000,  // push slot on free chain
        S_DONE      = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    opcode_t                   op_reg, op_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic [IW-1:0]             cur_reg, cur_next;     // slot under work
    logic [IW-1:0]             prv_reg, prv_next;     // captured prev link
    logic [IW-1:0]             nxt_reg, nxt_next;     // captured next link
    logic [AW-1:0]             steps_reg, steps_next;
    logic [IW-1:0]             head_reg, head_next;
    logic [IW-1:0]             tail_reg, tail_next;
    logic [IW-1:0]             free_reg, free_next;
    logic [IW-1:0]             fresh_reg, fresh_next;
    logic [IW-1:0]             count_reg, count_next;
    status_t                   status_reg, status_next;
    logic signed [VALUE_W-1:0] removed_reg, removed_next;

    // node store ports
    logic               val_we, nxt_we, prv_we;
    logic [AW-1:0]      val_waddr, nxt_waddr, prv_waddr;
    logic [VALUE_W-1:0] val_wdata;
    logic [IW-1:0]      nxt_wdata, prv_wdata;
    logic [VALUE_W-1:0] val_rdata;
    logic [IW-1:0]      nxt_rdata, prv_rdata;
    logic [AW-1:0]      raddr;

    logic accept;
    logic match;

    assign accept = start && (state_reg == S_IDLE);
    assign raddr  = cur_reg[AW-1:0];

    // the one shared comparator, used once per visited node
    assign match = (val_rdata == val_reg);

    dqdel_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_value_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (raddr),
        .rdata (val_rdata)
    );

    dqdel_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_next_ram (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .raddr (raddr),
        .rdata (nxt_rdata)
    );

    dqdel_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_prev_ram (
        .clk   (clk),
        .we    (prv_we),
        .waddr (prv_waddr),
        .wdata (prv_wdata),
        .raddr (raddr),
        .rdata (prv_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        val_next     = val_reg;
        cur_next     = cur_reg;
        prv_next     = prv_reg;
        nxt_next     = nxt_reg;
        steps_next   = steps_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        free_next    = free_reg;
        fresh_next   = fresh_reg;
        count_next   = count_reg;
        status_next  = status_reg;
        removed_next = removed_reg;

        val_we    = 1'b0;
        val_waddr = cur_reg[AW-1:0];
        val_wdata = val_reg;
        nxt_we    = 1'b0;
        nxt_waddr = cur_reg[AW-1:0];
        nxt_wdata = head_reg;
        prv_we    = 1'b0;
        prv_waddr = cur_reg[AW-1:0];
        prv_wdata = NIL;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next      = opcode_t'(opcode);
                    val_next     = item_value;
                    steps_next   = '0;
                    status_next  = ST_OK;
                    removed_next = '0;
                    if (opcode_t'(opcode) == OP_INSERT_FRONT)
                    begin
                        if (free_reg < NIL)
                        begin
                            // reuse a freed slot, need its chain link first
                            cur_next   = free_reg;
                            state_next = S_LOAD;
                        end
                        else if (fresh_reg < NIL)
                        begin
                            cur_next   = fresh_reg;
                            fresh_next = fresh_reg + 1'b1;
                            state_next = S_INS_LINK;
                        end
                        else
                        begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end
                    end
                    else if (head_reg >= NIL)
                    begin
                        status_next = ST_EMPTY;
                        state_next  = S_DONE;
                    end
                    else if (opcode_t'(opcode) == OP_DEL_LAST)
                    begin
                        if (tail_reg < NIL)
                        begin
                            cur_next   = tail_reg;
                            state_next = S_LOAD;
                        end
                        else
                        begin
                            status_next = ST_EMPTY;
                            state_next  = S_DONE;
                        end
                    end
                    else
                    begin
                        cur_next   = head_reg;
                        state_next = S_LOAD;
                    end
                end
            end

            S_LOAD:
            begin
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                if (op_reg == OP_INSERT_FRONT)
                begin
                    free_next  = nxt_rdata;
                    state_next = S_INS_LINK;
                end
                else if ((op_reg != OP_DEL_VALUE) || match)
                begin
                    prv_next     = prv_rdata;
                    nxt_next     = nxt_rdata;
                    removed_next = val_rdata;
                    state_next   = S_UNL_LINK;
                end
                else if ((nxt_rdata >= NIL) || (steps_reg == LAST_STEP))
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
                else
                begin
                    cur_next   = nxt_rdata;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_LOAD;
                end
            end

            S_INS_LINK:
            begin
                val_we     = 1'b1;
                nxt_we     = 1'b1;
                prv_we     = 1'b1;
                state_next = S_INS_FIX;
            end

            S_INS_FIX:
            begin
                if (head_reg < NIL)
                begin
                    prv_we    = 1'b1;
                    prv_waddr = head_reg[AW-1:0];
                    prv_wdata = cur_reg;
                end
                else
                begin
                    tail_next = cur_reg;
                end
                head_next  = cur_reg;
                count_next = count_reg + 1'b1;
                state_next = S_DONE;
            end

            S_UNL_LINK:
            begin
                if (prv_reg < NIL)
                begin
                    nxt_we    = 1'b1;
                    nxt_waddr = prv_reg[AW-1:0];
                    nxt_wdata = nxt_reg;
                end
                else
                begin
                    head_next = nxt_reg;
                end
                if (nxt_reg < NIL)
                begin
                    prv_we    = 1'b1;
                    prv_waddr = nxt_reg[AW-1:0];
                    prv_wdata = prv_reg;
                end
                else
                begin
                    tail_next = prv_reg;
                end
                state_next = S_UNL_FREE;
            end

            S_UNL_FREE:
            begin
                nxt_we    = 1'b1;
                nxt_wdata = free_reg;
                free_next = cur_reg;
                if (count_reg != '0)
                begin
                    count_next = count_reg - 1'b1;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= NIL;
            tail_reg  <= NIL;
            free_reg  <= NIL;
            fresh_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            free_reg  <= free_next;
            fresh_reg <= fresh_next;
            count_reg <= count_next;
        end
    end

    // working registers and result payload
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        val_reg     <= val_next;
        cur_reg     <= cur_next;
        prv_reg     <= prv_next;
        nxt_reg     <= nxt_next;
        steps_reg   <= steps_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
    end

    // result beat
    assign busy          = (state_reg != S_IDLE);
    assign done          = (state_reg == S_DONE);
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign entry_count   = COUNT_W'(count_reg);

    // checks
    a_state_onehot : assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NIL)
        else $error("entry count above capacity");

    a_empty_consistent : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ((head_reg == NIL) == (count_reg == '0)))
        else $error("head pointer and count disagree on empty list");

    a_ends_consistent : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ((head_reg == NIL) == (tail_reg == NIL)))
        else $error("head and tail disagree on empty list");

    a_full_status : assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status_reg == ST_FULL)) |-> (count_reg == NIL))
        else $error("full reported while slots remain");

    a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("command taken but unit not busy");

endmodule : deque_with_delete_by_value_unit

`default_nettype wire

// ===== sim/tb_deque_with_delete_by_value_unit.sv =====
// ----------------------------------------------------------------------------
// tb_deque_with_delete_by_value_unit
// self-checking bench for the bounded doubly linked list unit
// ----------------------------------------------------------------------------
// a table of directed commands covers the empty-list deletes, extreme values,
// the no-match search, duplicate values and single-entry lists; random traffic
// follows, including one pass that grows a long list, searches it end to end
// and drains it again. a behavioral copy of the list predicts each result beat
// that the table does not type in; every beat is compared field by field
// ----------------------------------------------------------------------------
`default_nettype none

module tb_deque_with_delete_by_value_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import dqdel_pkg::*;

    localparam int CAPACITY     = 1024;
    localparam int NIL          = CAPACITY;   // null link code
    localparam int MAX_GAP      = 10;
    localparam int RANDOM_BURST = 210;        // random beats per random phase
    localparam int LONG_LIST    = 64;         // entries grown for the deep walks
    localparam int TABLE_ROWS   = 24;

    // one result beat as the unit reports it
    typedef struct {
        status_t                   status;
        logic signed [VALUE_W-1:0] removed;
        logic [COUNT_W-1:0]        count;
    } list_reply_t;

    // one row of the directed table; checked marks rows whose reply is typed in
    typedef struct packed {
        opcode_t            op;
        logic [VALUE_W-1:0] value;
        bit                 checked;
        status_t            status;
        logic [VALUE_W-1:0] removed;
        logic [COUNT_W-1:0] count;
    } table_row_t;

    localparam table_row_t DIRECTED [TABLE_ROWS] = '{
        // every delete kind on an empty list
        '{OP_DEL_FIRST,    32'h0000_0000, 1'b1, ST_EMPTY,     32'h0000_0000, 11'd0},
        '{OP_DEL_LAST,     32'h0000_0000, 1'b1, ST_EMPTY,     32'h0000_0000, 11'd0},
        '{OP_DEL_VALUE,    32'h0000_0005, 1'b1, ST_EMPTY,     32'h0000_0000, 11'd0},
        // extreme values, and the largest one twice
        '{OP_INSERT_FRONT, 32'h7FFF_FFFF, 1'b1, ST_OK,        32'h0000_0000, 11'd1},
        '{OP_INSERT_FRONT, 32'h8000_0000, 1'b1, ST_OK,        32'h0000_0000, 11'd2},
        '{OP_INSERT_FRONT, 32'h0000_0000, 1'b1, ST_OK,        32'h0000_0000, 11'd3},
        '{OP_INSERT_FRONT, 32'hFFFF_FFFF, 1'b1, ST_OK,        32'h0000_0000, 11'd4},
        '{OP_INSERT_FRONT, 32'h7FFF_FFFF, 1'b1, ST_OK,        32'h0000_0000, 11'd5},
        // duplicate: only the copy nearest the head goes
        '{OP_DEL_VALUE,    32'h7FFF_FFFF, 1'b1, ST_OK,        32'h7FFF_FFFF, 11'd4},
        '{OP_DEL_VALUE,    32'h1234_5678, 1'b1, ST_NOT_FOUND, 32'h0000_0000, 11'd4},
        '{OP_DEL_VALUE,    32'h7FFF_FFFF, 1'b1, ST_OK,        32'h7FFF_FFFF, 11'd3},
        '{OP_DEL_FIRST,    32'h0000_0000, 1'b1, ST_OK,        32'hFFFF_FFFF, 11'd2},
        '{OP_DEL_LAST,     32'h0000_0000, 1'b1, ST_OK,        32'h8000_0000, 11'd1},
        // reuse of freed slots, delete from the middle, tail and head
        '{OP_INSERT_FRONT, 32'h5555_5555, 1'b0, ST_OK,        32'h0000_0000, 11'd0},
        '{OP_INSERT_FRONT, 32'hAAAA_AAAA, 1'b0, ST_OK,        32'h0000_0000, 11'd0},
        '{OP_DEL_VALUE,    32'h5555_5555, 1'b0, ST_OK,        32'h0000_0000, 11'd0},
        '{OP_DEL_VALUE,    32'h0000_0000, 1'b0, ST_OK,        32'h0000_0000, 11'd0},
        '{OP_INSERT_FRONT, 32'h0000_0000, 1'b0, ST_OK,        32'h0000_0000, 11'd0},
        '{OP_DEL_VALUE,    32'h0000_0000, 1'b0, ST_OK,        32'h0000_0000, 11'd0},
        '{OP_DEL_VALUE,    32'hAAAA_AAAA, 1'b0, ST_OK,        32'h0000_0000, 11'd0},
        // empty again
        '{OP_DEL_LAST,     32'h0000_0000, 1'b1, ST_EMPTY,     32'h0000_0000, 11'd0},
        '{OP_DEL_VALUE,    32'h0000_0000, 1'b1, ST_EMPTY,     32'h0000_0000, 11'd0},
        // single entry: head and tail are the same slot
        '{OP_INSERT_FRONT, 32'h0000_0001, 1'b1, ST_OK,        32'h0000_0000, 11'd1},
        '{OP_DEL_LAST,     32'h0000_0000, 1'b1, ST_OK,        32'h0000_0001, 11'd0}
    };

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [1:0]                opcode;
    logic signed [VALUE_W-1:0] item_value;
    logic                      done;
    logic [1:0]                status;
    logic signed [VALUE_W-1:0] removed_value;
    logic [COUNT_W-1:0]        entry_count;

    // behavioral copy of the list, advanced at every accepted command beat
    logic signed [VALUE_W-1:0] slot_value [CAPACITY];
    int                        slot_next  [CAPACITY];
    int                        slot_prev  [CAPACITY];
    int                        head_slot;
    int                        tail_slot;
    int                        live_count;
    int                        free_head;    // free chain, linked through slot_next
    int                        fresh_slot;   // lowest slot never used

    list_reply_t               awaited_replies [$];
    int                        mismatch_count = 0;
    bit                        no_idle = 1'b0;

    deque_with_delete_by_value_unit #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .item_value   (item_value),
        .done         (done),
        .status       (status),
        .removed_value(removed_value),
        .entry_count  (entry_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // take slot s out of the list, hand it to the free chain, return its value
    function automatic logic signed [VALUE_W-1:0] detach_slot(int s);
        int p;
        int n;
        p = slot_prev[s];
        n = slot_next[s];
        if (p < NIL)
            slot_next[p] = n;
        else
            head_slot = n;
        if (n < NIL)
            slot_prev[n] = p;
        else
            tail_slot = p;
        slot_next[s] = free_head;
        free_head = s;
        if (live_count > 0)
            live_count--;
        return slot_value[s];
    endfunction

    // apply one command to the list copy and return the reply it must produce
    function automatic list_reply_t model_list_op(opcode_t op,
                                                  logic signed [VALUE_W-1:0] v);
        list_reply_t r;
        int          s;
        int          cur;
        int          steps;
        bit          found;
        r.status  = ST_OK;
        r.removed = '0;
        if (op == OP_INSERT_FRONT)
        begin
            // freed slots first, then untouched ones
            if (free_head < NIL)
            begin
                s = free_head;
                free_head = slot_next[s];
            end
            else if (fresh_slot < NIL)
            begin
                s = fresh_slot;
                fresh_slot++;
            end
            else
                s = NIL;
            if (s >= NIL)
                r.status = ST_FULL;
            else
            begin
                slot_value[s] = v;
                slot_prev[s]  = NIL;
                slot_next[s]  = head_slot;
                if (head_slot < NIL)
                    slot_prev[head_slot] = s;
                else
                    tail_slot = s;
                head_slot = s;
                live_count++;
            end
        end
        else if (head_slot >= NIL)
            r.status = ST_EMPTY;
        else if (op == OP_DEL_VALUE)
        begin
            // walk from the head, first match wins
            cur   = head_slot;
            steps = 0;
            found = 1'b0;
            while (cur < NIL && steps < CAPACITY && !found)
            begin
                if (slot_value[cur] == v)
                    found = 1'b1;
                else
                begin
                    cur = slot_next[cur];
                    steps++;
                end
            end
            if (found)
                r.removed = detach_slot(cur);
            else
                r.status = ST_NOT_FOUND;
        end
        else if (op == OP_DEL_FIRST)
            r.removed = detach_slot(head_slot);
        else if (tail_slot < NIL)
            r.removed = detach_slot(tail_slot);
        else
            r.status = ST_EMPTY;
        r.count = live_count[COUNT_W-1:0];
        return r;
    endfunction

    // value of an entry picked at random among the first depth entries
    function automatic logic signed [VALUE_W-1:0] stored_value_near_head(int depth);
        int k;
        int cur;
        k   = $urandom_range(0, (live_count < depth ? live_count : depth) - 1);
        cur = head_slot;
        repeat (k) cur = slot_next[cur];
        return slot_value[cur];
    endfunction

    // small values collide often, which gives duplicates and matches
    function automatic logic signed [VALUE_W-1:0] draw_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                v = $urandom_range(0, 7);
                v = v - 4;
            end
            4:
            begin
                case ($urandom_range(0, 3))
                    0:       v = 32'sh7FFF_FFFF;
                    1:       v = 32'sh8000_0000;
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // keeps random lists short, so searches stay cheap
    function automatic int balanced_insert_pct();
        return live_count < 8 ? 60 : (live_count > 40 ? 30 : 48);
    endfunction

    // one command beat: random idle gap, then start held until accepted
    task automatic issue_command(input opcode_t op, input logic signed [VALUE_W-1:0] v,
                                 input bit checked, input list_reply_t typed_reply);
        int          gap;
        list_reply_t predicted;
        // switch now and then into a stretch with no idling
        if ($urandom_range(0, 39) == 0)
            no_idle = !no_idle;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        repeat (gap)
        begin
            @(negedge clk);
            start = 1'b0;
        end
        @(negedge clk);
        start      = 1'b1;
        opcode     = op;
        item_value = v;
        // busy read here is the value before the edge
        do
            @(posedge clk);
        while (busy);
        predicted = model_list_op(op, v);
        if (checked)
            awaited_replies.push_back(typed_reply);
        else
            awaited_replies.push_back(predicted);
    endtask

    // random command; found values for searches come from the first depth entries
    task automatic random_command(input int insert_pct, input int depth);
        opcode_t                   op;
        logic signed [VALUE_W-1:0] v;
        int                        roll;
        list_reply_t               unused;
        roll = $urandom_range(0, 99);
        if (roll < insert_pct)
            op = OP_INSERT_FRONT;
        else
        begin
            roll = $urandom_range(0, 9);
            op = roll < 4 ? OP_DEL_VALUE : (roll < 7 ? OP_DEL_FIRST : OP_DEL_LAST);
        end
        v = draw_value();
        if (op == OP_DEL_VALUE && live_count > 0 && $urandom_range(0, 2) != 0)
            v = stored_value_near_head(depth);
        issue_command(op, v, 1'b0, unused);
    endtask

    // result beats cannot be stalled: each done cycle is checked on its closing edge
    always @(posedge clk)
    begin
        list_reply_t want;
        if (rst_n && done)
        begin
            if (awaited_replies.size() == 0)
            begin
                $error("result beat with no command outstanding");
                mismatch_count++;
            end
            else
            begin
                want = awaited_replies.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    mismatch_count++;
                end
                if (removed_value !== want.removed)
                begin
                    $error("removed_value: expected %0d, got %0d",
                           want.removed, removed_value);
                    mismatch_count++;
                end
                if (entry_count !== want.count)
                begin
                    $error("entry_count: expected %0d, got %0d", want.count, entry_count);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        table_row_t  row;
        list_reply_t typed;
        list_reply_t spare;

        rst_n      = 1'b0;
        start      = 1'b0;
        opcode     = OP_INSERT_FRONT;
        item_value = '0;
        head_slot  = NIL;
        tail_slot  = NIL;
        live_count = 0;
        free_head  = NIL;
        fresh_slot = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // directed table
        for (int i = 0; i < TABLE_ROWS; i++)
        begin
            row           = DIRECTED[i];
            typed.status  = row.status;
            typed.removed = row.removed;
            typed.count   = row.count;
            issue_command(row.op, row.value, row.checked, typed);
        end

        // short random lists
        repeat (RANDOM_BURST) random_command(balanced_insert_pct(), 32);

        // grow a long list for the deep walks
        while (live_count < LONG_LIST)
            issue_command(OP_INSERT_FRONT, draw_value(), 1'b0, spare);
        // longest walks: match at the tail, then likely misses
        issue_command(OP_DEL_VALUE, slot_value[tail_slot], 1'b0, spare);
        repeat (2) issue_command(OP_DEL_VALUE, $urandom, 1'b0, spare);
        // churn on the long list with deep searches
        repeat (20) random_command(50, LONG_LIST);
        // drain to empty
        while (live_count > 0) random_command(0, 16);

        // short random lists again, starting empty
        repeat (RANDOM_BURST) random_command(balanced_insert_pct(), 32);

        @(negedge clk);
        start = 1'b0;
        while (awaited_replies.size() != 0) @(posedge clk);
        // room for any stray beat after the longest walk
        repeat (2 * CAPACITY + 8) @(posedge clk);
        if (mismatch_count == 0)
            $display("deque_with_delete_by_value_unit regression: pass");
        else
            $display("deque_with_delete_by_value_unit regression: fail");
        $finish;
    end

    // hang guard, several times the slowest expected run
    initial
    begin
        #10_000_000;
        $display("deque_with_delete_by_value_unit regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
sv/dqdel_pkg.sv
sv/dqdel_ram.sv
sv/deque_with_delete_by_value_unit.sv
sim/tb_deque_with_delete_by_value_unit.sv
